FILE: hw/rtl/nls_pkg.sv
// Shared types and constants of the leapfrog grid step block.
package nls_pkg;

    // Grid value format: signed Q2.14.
    localparam int VALUE_BITS = 16;
    localparam int FRAC       = VALUE_BITS - 2;
    localparam int COEFF_BITS = 24;
    localparam int NPTS_BITS  = 11;
    localparam int CFG_BITS   = 24;
    localparam int CFG_IDX_BITS = 3;

    // Item kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_D   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOW_RE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOW_IM   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BHIGH_RE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BHIGH_IM  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_N_POINTS  = 3'd6;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [9:0]                   point_index;
        logic signed [VALUE_BITS-1:0] value_re;
        logic signed [VALUE_BITS-1:0] value_im;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] out_re;
        logic signed [VALUE_BITS-1:0] out_im;
        logic [31:0]                  steps_done;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;
        logic pt_write;
        logic sweep_clr;
        logic sweep_run;
        logic advance;
        logic load_out;
    } nls_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] kind;
        logic       sweep_last;
        logic       pipe_busy;
    } nls_stat_t;

endpackage

FILE: hw/rtl/nls_leapfrog_grid_step.sv
// Top level of the 1D nonlinear Schrodinger leapfrog grid step block.
//
// Input channel in_valid/in_ready/in_data carries items of three kinds: write
// a point of the current grid, read a point of it, or advance one time step.
// Each item produces exactly one result on out_valid/out_ready/out_data with
// the point read (zero for other kinds) and the step count after the item.
// Configuration goes through cfg_we/cfg_index/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A write or read is latched, dispatched and loaded into the output register.
// A step sweeps the n points in use: the sweep reads one point per cycle
// from the current grid bank; the arithmetic pipeline drains before rotation.
// One item is worked on at a time; a new item is taken while the previous
// result still waits in the output register.
// When the receiver stalls, the result holds and the next item stops at its
// end until the output register frees.
// Reset clears the step count, the grid rotation and the configuration to
// defaults; grid contents are undefined until written.
module nls_leapfrog_grid_step
    import nls_pkg::*;
#(
    parameter int GRID_POINTS = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_item_t                in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_item_t               out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    nls_cmd_t  cmd;
    nls_stat_t stat;

    nls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nls_datapath #(
        .GRID_POINTS (GRID_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/nls_ctrl.sv
// Controller state machine sequencing item handling and grid sweeps.
module nls_ctrl
    import nls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  nls_stat_t stat,
    output nls_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (stat.kind == KIND_STEP)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_SWEEP;
                end
                else
                begin
                    cmd.pt_write = (stat.kind == KIND_WRITE);
                    state_next   = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/nls_datapath.sv
// Grid memories, configuration, stencil window and arithmetic pipeline.
module nls_datapath
    import nls_pkg::*;
#(
    parameter int GRID_POINTS = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  in_item_t                in_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  nls_cmd_t                cmd,
    output nls_stat_t               stat,
    output out_item_t               out_data
);

    localparam int AW   = $clog2(GRID_POINTS);
    localparam int CMPW = (AW + 1 > NPTS_BITS) ? AW + 1 : NPTS_BITS;
    localparam logic [CMPW-1:0] GRID_C  = CMPW'(GRID_POINTS);
    localparam logic [CMPW-1:0] MIN_PTS = CMPW'(3);

    typedef logic [2*VALUE_BITS-1:0] cplx_t;

    // Configuration registers.
    logic [COEFF_BITS-1:0]        coeff_d_reg, time_step_reg;
    logic signed [VALUE_BITS-1:0] blow_re_reg, blow_im_reg, bhigh_re_reg, bhigh_im_reg;
    logic [NPTS_BITS-1:0]         n_points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_d_reg   <= COEFF_BITS'(65536);
            time_step_reg <= COEFF_BITS'(655);
            blow_re_reg   <= '0;
            blow_im_reg   <= '0;
            bhigh_re_reg  <= '0;
            bhigh_im_reg  <= '0;
            n_points_reg  <= NPTS_BITS'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEFF_D:   coeff_d_reg   <= cfg_data;
                REG_TIME_STEP: time_step_reg <= cfg_data;
                REG_BLOW_RE:   blow_re_reg   <= cfg_data[VALUE_BITS-1:0];
                REG_BLOW_IM:   blow_im_reg   <= cfg_data[VALUE_BITS-1:0];
                REG_BHIGH_RE:  bhigh_re_reg  <= cfg_data[VALUE_BITS-1:0];
                REG_BHIGH_IM:  bhigh_im_reg  <= cfg_data[VALUE_BITS-1:0];
                REG_N_POINTS:  n_points_reg  <= cfg_data[NPTS_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Effective point count, clamped between 3 and the grid size.
    logic [CMPW-1:0] npts_w, n_eff_w;
    logic [AW:0]     n_eff;

    always_comb
    begin
        npts_w = CMPW'(n_points_reg);
        if (npts_w < MIN_PTS)
            n_eff_w = MIN_PTS;
        else if (npts_w > GRID_C)
            n_eff_w = GRID_C;
        else
            n_eff_w = npts_w;
    end
    assign n_eff = n_eff_w[AW:0];

    // Latched item and its address check.
    in_item_t item_reg;
    logic     idx_ok;
    logic [AW-1:0] item_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= in_data;
    end
    assign idx_ok    = (CMPW'(item_reg.point_index) < n_eff_w);
    assign item_addr = AW'(item_reg.point_index);

    // Rotation and step counter.
    logic [1:0]  rot_reg, cur_b, nxt_b, old_b;
    logic [31:0] step_count_reg;
    logic        first_step;

    assign cur_b      = rot_reg;
    assign nxt_b      = (rot_reg == 2'd2) ? 2'd0 : rot_reg + 2'd1;
    assign old_b      = (rot_reg == 2'd0) ? 2'd2 : rot_reg - 2'd1;
    assign first_step = (step_count_reg == 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg        <= 2'd0;
            step_count_reg <= 32'd0;
        end
        else if (cmd.advance)
        begin
            rot_reg        <= nxt_b;
            step_count_reg <= step_count_reg + 32'd1;
        end
    end

    // Sweep counter: issues reads of points 0 to n, the last one for the right boundary.
    logic [AW:0]   r_reg;
    logic [AW-1:0] r_addr, r_prev;

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_clr)
            r_reg <= '0;
        else if (cmd.sweep_run)
            r_reg <= r_reg + 1'b1;
    end
    assign r_addr = r_reg[AW-1:0];
    assign r_prev = r_addr - 1'b1;

    // Three grid banks; roles rotate between current, next and old.
    logic [AW-1:0] raddr [3];
    logic [AW-1:0] waddr [3];
    cplx_t         wdata [3];
    cplx_t         rdata [3];
    logic [2:0]    bank_we;

    logic          nw_en;
    logic [AW-1:0] nw_addr;
    cplx_t         nw_data;

    genvar b;
    generate
        for (b = 0; b < 3; b++)
        begin : g_bank
            cplx_t mem [GRID_POINTS];

            always_comb
            begin
                raddr[b] = (2'(b) == cur_b) ? (cmd.sweep_run ? r_addr : item_addr) : r_prev;
                if (2'(b) == nxt_b)
                begin
                    bank_we[b] = nw_en;
                    waddr[b]   = nw_addr;
                    wdata[b]   = nw_data;
                end
                else
                begin
                    bank_we[b] = (2'(b) == cur_b) && cmd.pt_write && idx_ok;
                    waddr[b]   = item_addr;
                    wdata[b]   = {item_reg.value_re, item_reg.value_im};
                end
            end

            always_ff @(posedge clk)
            begin
                if (bank_we[b])
                    mem[waddr[b]] <= wdata[b];
                rdata[b] <= mem[raddr[b]];
            end
        end
    endgenerate

    cplx_t cur_q, old_q;
    assign cur_q = rdata[cur_b];
    assign old_q = rdata[old_b];

    // Data arrival stage tags.
    logic          dv_reg, dfirst_reg, dbound_reg;
    logic [AW-1:0] didx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= 1'b0;
        else
            dv_reg <= cmd.sweep_run;
    end

    always_ff @(posedge clk)
    begin
        dfirst_reg <= (r_reg == '0);
        dbound_reg <= (r_reg == n_eff);
        didx_reg   <= r_prev;
    end

    // Stencil window: left and center points.
    cplx_t win_l_reg, win_c_reg, right_v;
    assign right_v = dbound_reg ? {bhigh_re_reg, bhigh_im_reg} : cur_q;

    always_ff @(posedge clk)
    begin
        if (dv_reg)
        begin
            if (dfirst_reg)
            begin
                win_l_reg <= {blow_re_reg, blow_im_reg};
                win_c_reg <= cur_q;
            end
            else
            begin
                win_l_reg <= win_c_reg;
                win_c_reg <= right_v;
            end
        end
    end

    // Laplacian of the center point.
    logic signed [17:0] l_re, l_im, c_re, c_im, rr_re, rr_im, lap_re, lap_im;
    assign l_re   = $signed(win_l_reg[31:16]);
    assign l_im   = $signed(win_l_reg[15:0]);
    assign c_re   = $signed(win_c_reg[31:16]);
    assign c_im   = $signed(win_c_reg[15:0]);
    assign rr_re  = $signed(right_v[31:16]);
    assign rr_im  = $signed(right_v[15:0]);
    assign lap_re = l_re + rr_re - (c_re <<< 1);
    assign lap_im = l_im + rr_im - (c_im <<< 1);

    // Pipeline valid bits, stages 1 to 6.
    logic [6:1] sv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= '0;
        else
            sv_reg <= {sv_reg[5:1], dv_reg && !dfirst_reg};
    end

    // Center, old value and index travel along the pipeline.
    cplx_t         pc_reg [1:6];
    cplx_t         po_reg [1:6];
    logic [AW-1:0] pi_reg [1:6];

    always_ff @(posedge clk)
    begin
        pc_reg[1] <= win_c_reg;
        po_reg[1] <= old_q;
        pi_reg[1] <= didx_reg;
        for (int s = 2; s <= 6; s++)
        begin
            pc_reg[s] <= pc_reg[s-1];
            po_reg[s] <= po_reg[s-1];
            pi_reg[s] <= pi_reg[s-1];
        end
    end

    // Stage 1: Laplacian.
    logic signed [17:0] lap_re_reg, lap_im_reg;
    always_ff @(posedge clk)
    begin
        lap_re_reg <= lap_re;
        lap_im_reg <= lap_im;
    end

    // Stage 2: coefficient products and squares.
    logic signed [42:0] pa_reg, pb_reg;
    logic signed [31:0] sq_re_reg, sq_im_reg;
    logic signed [VALUE_BITS-1:0] s1_re, s1_im;
    assign s1_re = pc_reg[1][31:16];
    assign s1_im = pc_reg[1][15:0];

    always_ff @(posedge clk)
    begin
        pa_reg    <= $signed({1'b0, coeff_d_reg}) * lap_im_reg;
        pb_reg    <= $signed({1'b0, coeff_d_reg}) * lap_re_reg;
        sq_re_reg <= s1_re * s1_re;
        sq_im_reg <= s1_im * s1_im;
    end

    // Stage 3: round the diffusion terms, squared magnitude.
    logic signed [43:0] pa_w, pb_w, ta_w, tb_w;
    logic [32:0]        mag;
    logic signed [27:0] ta_reg, tb_reg;
    logic [18:0]        m_reg;

    assign pa_w = pa_reg;
    assign pb_w = pb_reg;
    assign ta_w = first_step ? ((pa_w + 44'sd65536) >>> 17) : ((pa_w + 44'sd32768) >>> 16);
    assign tb_w = first_step ? ((pb_w + 44'sd65536) >>> 17) : ((pb_w + 44'sd32768) >>> 16);
    assign mag  = 33'(unsigned'(sq_re_reg)) + 33'(unsigned'(sq_im_reg))
                + 33'(1 << (FRAC - 1));

    always_ff @(posedge clk)
    begin
        ta_reg <= 28'(ta_w);
        tb_reg <= 28'(tb_w);
        m_reg  <= 19'(mag >> FRAC);
    end

    // Stages 4 to 5: cubic weight k = rnd(dt * m, 16).
    logic [42:0] dtm_reg;
    logic [43:0] dtm_w;
    logic [27:0] k_reg;
    logic signed [27:0] ta4_reg, tb4_reg, ta5_reg, tb5_reg, ta6_reg, tb6_reg;

    assign dtm_w = 44'(dtm_reg) + 44'd32768;

    always_ff @(posedge clk)
    begin
        dtm_reg <= time_step_reg * m_reg;
        k_reg   <= 28'(dtm_w >> 16);
        ta4_reg <= ta_reg;
        tb4_reg <= tb_reg;
        ta5_reg <= ta4_reg;
        tb5_reg <= tb4_reg;
        ta6_reg <= ta5_reg;
        tb6_reg <= tb5_reg;
    end

    // Stage 6: k times the center point.
    logic signed [44:0] kc_re_reg, kc_im_reg;
    logic signed [VALUE_BITS-1:0] s5_re, s5_im;
    assign s5_re = pc_reg[5][31:16];
    assign s5_im = pc_reg[5][15:0];

    always_ff @(posedge clk)
    begin
        kc_re_reg <= $signed({1'b0, k_reg}) * s5_re;
        kc_im_reg <= $signed({1'b0, k_reg}) * s5_im;
    end

    // Final sums, saturation and write into the next grid.
    logic signed [45:0] kc_re_w, kc_im_w, p_w, q_w;
    logic signed [35:0] base_re, base_im, sum_re, sum_im;
    logic signed [VALUE_BITS-1:0] sat_re, sat_im;

    function automatic logic signed [VALUE_BITS-1:0] sat16(input logic signed [35:0] x);
        logic signed [35:0] mx, mn;
        mx = 36'sd32767;
        mn = -36'sd32768;
        if (x > mx)
            sat16 = 16'sh7fff;
        else if (x < mn)
            sat16 = 16'sh8000;
        else
            sat16 = x[VALUE_BITS-1:0];
    endfunction

    always_comb
    begin
        kc_re_w = kc_re_reg;
        kc_im_w = kc_im_reg;
        p_w     = (kc_re_w + 46'sd8192) >>> FRAC;
        q_w     = (kc_im_w + 46'sd8192) >>> FRAC;
        if (first_step)
        begin
            base_re = $signed(pc_reg[6][31:16]);
            base_im = $signed(pc_reg[6][15:0]);
            sum_re  = base_re + ta6_reg;
            sum_im  = base_im - tb6_reg;
        end
        else
        begin
            base_re = $signed(po_reg[6][31:16]);
            base_im = $signed(po_reg[6][15:0]);
            sum_re  = base_re + ta6_reg + 36'(q_w);
            sum_im  = base_im - tb6_reg - 36'(p_w);
        end
        sat_re = sat16(sum_re);
        sat_im = sat16(sum_im);
    end

    assign nw_en   = sv_reg[6];
    assign nw_addr = pi_reg[6];
    assign nw_data = {sat_re, sat_im};

    // Result register.
    logic rd_hit;
    assign rd_hit = (item_reg.kind == KIND_READ) && idx_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data.out_re     <= rd_hit ? $signed(cur_q[31:16]) : '0;
            out_data.out_im     <= rd_hit ? $signed(cur_q[15:0]) : '0;
            out_data.steps_done <= step_count_reg;
        end
    end

    // Status to the controller.
    assign stat.kind       = item_reg.kind;
    assign stat.sweep_last = (r_reg == n_eff);
    assign stat.pipe_busy  = dv_reg || (|sv_reg);

endmodule

FILE: hw/rtl/nls_checker.sv
// Port-level checker for the grid step block, bound to the top level.
module nls_checker
    import nls_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    logic        in_acc, out_acc;
    logic [1:0]  pend_reg;
    logic [31:0] last_steps_reg;
    logic        seen_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Items accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 2'd0;
            seen_reg       <= 1'b0;
            last_steps_reg <= 32'd0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_acc) - 2'(out_acc);
            if (out_acc)
            begin
                seen_reg       <= 1'b1;
                last_steps_reg <= out_data.steps_done;
            end
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // No result without an accepted item.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an item");

    // At most one item in work besides a waiting result.
    a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !in_ready)
        else $error("too many items in flight");

    // The step count grows by at most one per result.
    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg |->
            out_data.steps_done == last_steps_reg ||
            out_data.steps_done == last_steps_reg + 32'd1)
        else $error("step count jumped");

endmodule

bind nls_leapfrog_grid_step nls_checker u_nls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
